FILE: rtl/core/fire_heat_diffusion_assert.svh
// assertion macros for the fire heat diffusion block
// used by rtl files that carry concurrent checks; no other dependencies
`ifndef FIRE_HEAT_DIFFUSION_ASSERT_SVH
`define FIRE_HEAT_DIFFUSION_ASSERT_SVH
`ifndef NO_ASSERTIONS
// clocked check, disabled while reset is asserted (active low)
`define FHD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// clocked check with no reset qualifier
`define FHD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FHD_ASSERT(lbl, clk, rstn, prop, msg)
`define FHD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/core/fhd_pkg.sv
// shared types and constants of the fire heat diffusion block
// no dependencies; used by every module of the block
package fhd_pkg;

    localparam int HEAT_W       = 8;
    localparam int OUT_INDEX_W  = 20;
    localparam int CFG_W        = 11;
    localparam int SUM_W        = 11;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MIN_DIM        = 3;
    localparam int ROW_WIDTH_RST  = 640;
    localparam int ROW_COUNT_RST  = 480;

    // sum / 6 as (sum * 2731) >> 14, exact for sums up to 6 * 255
    localparam int DIV_MUL_W = 12;
    localparam int DIV_MUL   = 2731;
    localparam int DIV_SHIFT = 14;
    localparam int PROD_W    = SUM_W + DIV_MUL_W;

    // register indexes
    localparam logic REG_ROW_WIDTH = 1'b0;
    localparam logic REG_ROW_COUNT = 1'b1;

    typedef struct packed {
        logic [HEAT_W-1:0] heat_in;
        logic              frame_start;
    } in_t;

    typedef struct packed {
        logic [HEAT_W-1:0]      heat_out;
        logic [OUT_INDEX_W-1:0] out_index;
        logic                   frame_last;
    } out_t;

    // item after the line store read has been issued
    typedef struct packed {
        logic                   valid;
        logic                   produce;
        logic [HEAT_W-1:0]      heat;
        logic [OUT_INDEX_W-1:0] index;
        logic                   last;
    } stage_b_t;

    // window sum of an item that yields a result
    typedef struct packed {
        logic                   valid;
        logic [SUM_W-1:0]       sum;
        logic [OUT_INDEX_W-1:0] index;
        logic                   last;
    } stage_c_t;

endpackage

FILE: rtl/core/fhd_ram.sv
// generic single write port, single read port ram with registered read
// depends on fhd_pkg for default sizes
module fhd_ram #(
    parameter int WIDTH = fhd_pkg::HEAT_W,
    parameter int DEPTH = fhd_pkg::MAX_WIDTH_DEF + 2,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/fhd_window.sv
// six tap window: keeps the two previous samples of both rows and sums them
// depends on fhd_pkg for stage structs
module fhd_window (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           fill_shift,
    input  fhd_pkg::stage_b_t              stage_b,
    input  logic [fhd_pkg::HEAT_W-1:0]     rd_data,
    output fhd_pkg::stage_c_t              stage_c
);
    import fhd_pkg::*;

    // up taps come from the line store, cur taps from the stream itself
    logic [HEAT_W-1:0] up1_reg, up2_reg, cur1_reg, cur2_reg;
    logic [SUM_W-1:0]  sum_next;
    stage_c_t          stage_c_reg, stage_c_next;

    always_comb begin
        sum_next = SUM_W'(up2_reg) + SUM_W'(up1_reg) + SUM_W'(rd_data)
                 + SUM_W'(cur2_reg) + SUM_W'(cur1_reg) + SUM_W'(stage_b.heat);
        stage_c_next.valid = stage_b.valid && stage_b.produce;
        stage_c_next.sum   = sum_next;
        stage_c_next.index = stage_b.index;
        stage_c_next.last  = stage_b.last;
    end

    // up taps also shift in reload reads after a row width change
    always_ff @(posedge aclk) begin
        if (fill_shift || (en && stage_b.valid)) begin
            up2_reg  <= up1_reg;
            up1_reg  <= rd_data;
        end
        if (en && stage_b.valid) begin
            cur2_reg <= cur1_reg;
            cur1_reg <= stage_b.heat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_c_reg.valid <= 1'b0;
        end else if (en) begin
            stage_c_reg <= stage_c_next;
        end
    end

    assign stage_c = stage_c_reg;

endmodule

FILE: rtl/core/fhd_cool.sv
// divide by six, cool by one and hold the result in the output register
// depends on fhd_pkg for stage and result structs
module fhd_cool (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  fhd_pkg::stage_c_t stage_c,
    output logic              m_valid,
    output fhd_pkg::out_t     m_data
);
    import fhd_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [HEAT_W-1:0] quot;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;

    always_comb begin
        prod = PROD_W'(stage_c.sum) * PROD_W'(DIV_MUL);
        quot = prod[DIV_SHIFT +: HEAT_W];
        m_valid_next          = stage_c.valid;
        m_data_next.heat_out  = (quot != '0) ? quot - HEAT_W'(1) : quot;
        m_data_next.out_index = stage_c.index;
        m_data_next.frame_last = stage_c.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/core/fire_heat_diffusion.sv
// fire heat diffusion top: position tracking, line store ram, window, cooling
// depends on fhd_pkg, fhd_ram, fhd_window, fhd_cool and the assertion header
// throughput one sample per cycle outside stalls and reloads, set by the single line store read port
// a result passes stage_b, the window register and the output register before it is on m_
// a row_width write holds s_ready low while the up taps reload
// reset: position 0, row_width 640, row_count 480, pipeline empty; line store not cleared
`include "fire_heat_diffusion_assert.svh"
module fire_heat_diffusion #(
    parameter int MAX_WIDTH  = fhd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fhd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // sample stream
    input  logic                       s_valid,
    output logic                       s_ready,
    input  fhd_pkg::in_t               s_data,
    // result stream
    output logic                       m_valid,
    input  logic                       m_ready,
    output fhd_pkg::out_t              m_data,
    // configuration writes
    input  logic                       cfg_wr_en,
    input  logic                       cfg_index,
    input  logic [fhd_pkg::CFG_W-1:0]  cfg_wdata
);
    import fhd_pkg::*;

    localparam int DIM_W = $clog2(MAX_WIDTH + 1);
    localparam int H_W   = $clog2(MAX_HEIGHT + 1);
    localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CMP_W = (CFG_W > DIM_W ? CFG_W : DIM_W) + 1;
    localparam int CMPH_W = (CFG_W > H_W ? CFG_W : H_W) + 1;
    localparam int W_RST = (ROW_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : ROW_WIDTH_RST;
    localparam int H_RST = (ROW_COUNT_RST > MAX_HEIGHT) ? MAX_HEIGHT : ROW_COUNT_RST;
    // reads needed to reload the two older up taps
    localparam logic [1:0] REFILL_TAPS = 2'd2;

    // configuration, stored already clamped to the legal range
    logic [DIM_W-1:0] width_reg, width_next;
    logic [H_W-1:0]   height_reg, height_next;

    // raster position and the ring pointer into the line store
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;

    // up tap reload after a row width change
    logic [1:0]       refill_reg, refill_next;
    logic             fill_shift_reg, fill_shift_next;

    logic [DIM_W+H_W-1:0] prod;
    logic [POS_W-1:0]     pixels;
    logic [POS_W-1:0]     pos_cur;
    logic [POS_W-1:0]     first_out;
    logic [POS_W-1:0]     index_full;
    logic [AW-1:0]        wr_sel;
    logic [AW:0]          rd_wrap;
    logic [AW:0]          fill_off;
    logic [AW:0]          fill_wrap;
    logic [AW-1:0]        ram_rd_addr;
    logic                 ram_rd_en;
    logic                 ram_wr_en;
    logic [HEAT_W-1:0]    ram_rd_data;
    logic                 en;
    logic                 accept;
    logic                 in_frame;

    stage_b_t stage_b_reg, stage_b_next;
    stage_c_t stage_c;

    // the whole pipeline moves unless a result waits on a stalled output;
    // new samples also wait while the up taps reload
    assign en      = !m_valid || m_ready;
    assign s_ready = en && (refill_reg == 2'd0);
    assign accept  = s_valid && s_ready;

    // register writes, clamped on the way in
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        refill_next = (refill_reg != 2'd0) ? refill_reg - 2'd1 : 2'd0;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ROW_WIDTH: begin
                    // the up taps were fetched one old row back
                    refill_next = REFILL_TAPS;
                    if (CMP_W'(cfg_wdata) < CMP_W'(MIN_DIM)) begin
                        width_next = DIM_W'(MIN_DIM);
                    end else if (CMP_W'(cfg_wdata) > CMP_W'(MAX_WIDTH)) begin
                        width_next = DIM_W'(MAX_WIDTH);
                    end else begin
                        width_next = DIM_W'(cfg_wdata);
                    end
                end
                REG_ROW_COUNT: begin
                    if (CMPH_W'(cfg_wdata) < CMPH_W'(MIN_DIM)) begin
                        height_next = H_W'(MIN_DIM);
                    end else if (CMPH_W'(cfg_wdata) > CMPH_W'(MAX_HEIGHT)) begin
                        height_next = H_W'(MAX_HEIGHT);
                    end else begin
                        height_next = H_W'(cfg_wdata);
                    end
                end
                default: begin
                    width_next  = width_reg;
                    height_next = height_reg;
                end
            endcase
        end
    end

    // position of the incoming sample and what it causes
    always_comb begin
        prod       = (DIM_W+H_W)'(width_reg) * (DIM_W+H_W)'(height_reg);
        pixels     = prod[POS_W-1:0];
        pos_cur    = s_data.frame_start ? '0 : pos_reg;
        wr_sel     = s_data.frame_start ? '0 : wr_ptr_reg;
        // samples past the frame end are dropped
        in_frame   = pos_cur < pixels;
        first_out  = POS_W'({width_reg, 1'b1});
        index_full = pos_cur - first_out;

        // entry one row back, modulo the store depth
        if (AW'(wr_sel) >= AW'(width_reg)) begin
            rd_wrap = (AW+1)'(wr_sel) - (AW+1)'(width_reg);
        end else begin
            rd_wrap = (AW+1)'(wr_sel) + (AW+1)'(DEPTH) - (AW+1)'(width_reg);
        end

        // reload reads: one row back minus two, then minus one, from the next slot
        fill_off = (AW+1)'(width_reg) + (AW+1)'(refill_reg);
        if ((AW+1)'(wr_ptr_reg) >= fill_off) begin
            fill_wrap = (AW+1)'(wr_ptr_reg) - fill_off;
        end else begin
            fill_wrap = (AW+1)'(wr_ptr_reg) + (AW+1)'(DEPTH) - fill_off;
        end

        ram_rd_addr = (refill_reg != 2'd0) ? fill_wrap[AW-1:0] : rd_wrap[AW-1:0];
        ram_rd_en   = en || (refill_reg != 2'd0);
        ram_wr_en   = accept && in_frame;
        fill_shift_next = refill_reg != 2'd0;

        pos_next    = pos_reg;
        wr_ptr_next = wr_ptr_reg;
        if (ram_wr_en) begin
            pos_next    = pos_cur + POS_W'(1);
            wr_ptr_next = (wr_sel == AW'(DEPTH - 1)) ? '0 : wr_sel + AW'(1);
        end

        stage_b_next.valid   = ram_wr_en;
        stage_b_next.produce = pos_cur >= first_out;
        stage_b_next.heat    = s_data.heat_in;
        stage_b_next.index   = OUT_INDEX_W'(index_full);
        stage_b_next.last    = pos_cur == pixels - POS_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= DIM_W'(W_RST);
            height_reg     <= H_W'(H_RST);
            pos_reg        <= '0;
            wr_ptr_reg     <= '0;
            refill_reg     <= 2'd0;
            fill_shift_reg <= 1'b0;
        end else begin
            width_reg      <= width_next;
            height_reg     <= height_next;
            pos_reg        <= pos_next;
            wr_ptr_reg     <= wr_ptr_next;
            refill_reg     <= refill_next;
            fill_shift_reg <= fill_shift_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_b_reg.valid <= 1'b0;
        end else if (en) begin
            stage_b_reg <= stage_b_next;
        end
    end

    // line store: the write goes to the current slot while the read fetches
    // the slot one row back, which was written at least three transfers ago,
    // so the two never meet and no forwarding is needed
    fhd_ram #(
        .WIDTH (HEAT_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_sel),
        .wr_data (s_data.heat_in),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    fhd_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .fill_shift (fill_shift_reg),
        .stage_b    (stage_b_reg),
        .rd_data    (ram_rd_data),
        .stage_c    (stage_c)
    );

    fhd_cool u_cool (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .stage_c (stage_c),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    // checks
    `FHD_ASSERT(a_rw_apart, aclk, aresetn, !ram_wr_en || (ram_rd_addr != wr_sel), "line store read and write hit the same entry")
    `FHD_ASSERT(a_ptr_range, aclk, aresetn, wr_ptr_reg <= AW'(DEPTH - 1), "line store pointer out of range")
    `FHD_ASSERT(a_frame_restart, aclk, aresetn, (accept && s_data.frame_start) |=> (pos_reg == POS_W'(1) && wr_ptr_reg == AW'(1)), "frame start did not restart the position")
    `FHD_ASSERT(a_stall_hold, aclk, aresetn, (m_valid && !m_ready) |=> ($stable(stage_c.valid) && $stable(stage_b_reg.valid) && $stable(m_data)), "pipeline moved during an output stall")

endmodule
